### src/hict_pkg.sv
// Package for the histogram inverse-cdf table block.
// Shared widths of the stream payloads and parameter defaults; no dependencies.
package hict_pkg;

    localparam int DEF_BINS       = 256;
    localparam int DEF_CHANNELS   = 4;
    localparam int DEF_COUNT_BITS = 24;

    localparam int IDX_W  = 8;   // index field
    localparam int CH_W   = 2;   // channel field
    localparam int VAL_W  = 24;  // cdf_value field
    localparam int OUT_W  = 24;  // inverse_value field

    localparam int S_DATA_W = 32;  // index, cdf_value
    localparam int S_USER_W = 3;   // mode, channel
    localparam int M_DATA_W = 24;  // inverse_value

    localparam int OUT_SCALE = 255;

    localparam logic MODE_LOAD  = 1'b0;
    localparam logic MODE_QUERY = 1'b1;

endpackage

### src/hict_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module hict_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

### src/histogram_inverse_cdf_table.sv
// Top level of the histogram inverse-cdf table: cdf store, search and divider.
// Depends on hict_pkg and hict_ram.
//
//  channel | dir | tdata (low bit up)          | tuser (low bit up)
//  s_*     | in  | index[7:0], cdf_value[31:8] | mode[0], channel[2:1]
//  m_*     | out | inverse_value[23:0]         | -
//
// A load writes one bin. A query scans its channel's bins in ascending order, one
// per cycle through the registered read port of the cdf RAM, and stops at the first
// bin that qualifies; then a bit-serial multiply and a restoring divide of
// COUNT_BITS steps each. One item is worked at a time; a new item is taken while a
// result waits, and a finished query holds until the output register is free.
// Reset clears control only; the cdf RAM is undefined until loaded.
module histogram_inverse_cdf_table #(
    parameter int BINS       = hict_pkg::DEF_BINS,
    parameter int CHANNELS   = hict_pkg::DEF_CHANNELS,
    parameter int COUNT_BITS = hict_pkg::DEF_COUNT_BITS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    input  logic [hict_pkg::S_DATA_W-1:0] i_s_tdata,  // index, cdf_value
    input  logic [hict_pkg::S_USER_W-1:0] i_s_tuser,  // mode, channel
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    output logic [hict_pkg::M_DATA_W-1:0] o_m_tdata   // inverse_value
);

    import hict_pkg::*;

    localparam int CB     = COUNT_BITS;
    localparam int DEPTH  = CHANNELS * BINS;
    localparam int AW     = $clog2(DEPTH);
    localparam int IX     = $clog2(BINS);       // bin index
    localparam int TW     = CB + IDX_W + 1;     // (c+1)*T and q*255
    localparam int KD     = BINS * OUT_SCALE;
    localparam int KW     = $clog2(KD + 1);
    localparam int DEN_W  = CB + KW;
    localparam int NUM_W  = IX + CB + IDX_W + 1;
    localparam int PW     = NUM_W + CB;         // num * T
    localparam int RW     = NUM_W + 1;          // divider remainder
    localparam int QW     = CB + 1;             // result before truncation
    localparam int CNT_W  = $clog2(CB + 1);

    typedef enum logic [3:0] {
        ST_IDLE, ST_RDT, ST_T, ST_SCAN, ST_PQ,
        ST_NUM, ST_MUL, ST_DIVI, ST_DIV, ST_FIN, ST_DONE
    } t_state;

    t_state             r_state;
    logic [AW-1:0]      r_base;
    logic [IDX_W:0]     r_cp1;     // c + 1
    logic [CB-1:0]      r_total;
    logic [TW-1:0]      r_tgt;
    logic [IX-1:0]      r_ra;      // bin being read
    logic [IX-1:0]      r_ci;      // bin being compared
    logic [CB-1:0]      r_prev;
    logic [CB-1:0]      r_q, r_p;
    logic [IX+CB-1:0]   r_prod;
    logic [DEN_W-1:0]   r_den;
    logic [NUM_W-1:0]   r_num;
    logic [PW-1:0]      r_acc;
    logic [CB-1:0]      r_mulb;
    logic [CNT_W-1:0]   r_cnt;
    logic [RW-1:0]      r_rem;
    logic [CB-1:0]      r_dlo;
    logic [CB-1:0]      r_quo;
    logic [QW-1:0]      r_res;
    logic               r_out_valid;
    logic [OUT_W-1:0]   r_out_data;

    // input fields
    logic             s_mode;
    logic [CH_W-1:0]  s_ch;
    logic [IDX_W-1:0] s_idx;
    logic [VAL_W-1:0] s_val;
    logic             s_acc;
    logic             ch_ok;

    assign s_mode = i_s_tuser[0];
    assign s_ch   = i_s_tuser[CH_W:1];
    assign s_idx  = i_s_tdata[IDX_W-1:0];
    assign s_val  = i_s_tdata[IDX_W+VAL_W-1:IDX_W];
    assign ch_ok  = 32'(s_ch) < CHANNELS;

    assign o_s_tready = (r_state == ST_IDLE);
    assign s_acc      = i_s_tvalid && o_s_tready;

    // cdf RAM
    logic           ram_we;
    logic [AW-1:0]  ram_waddr, ram_raddr;
    logic [CB-1:0]  ram_wdata, ram_rdata;

    assign ram_we    = s_acc && (s_mode == MODE_LOAD) && ch_ok && (32'(s_idx) < BINS);
    assign ram_waddr = AW'(32'(s_ch) * BINS + 32'(s_idx));
    assign ram_wdata = CB'(s_val);

    // default address is bin 0, read while the total arrives
    always_comb begin
        case (r_state)
            ST_RDT:  ram_raddr = r_base + AW'(BINS - 1);
            ST_SCAN: ram_raddr = r_base + AW'(r_ra);
            default: ram_raddr = r_base;
        endcase
    end

    hict_ram #(
        .WIDTH (CB),
        .DEPTH (DEPTH)
    ) u_cdf_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // datapath helpers
    logic [TW-1:0]    q255;
    logic             hit;
    logic [CB-1:0]    span;
    logic [RW-1:0]    trial;
    logic             trial_ge;

    assign q255     = (TW'(ram_rdata) << 8) - TW'(ram_rdata);
    assign hit      = q255 >= r_tgt;
    assign span     = r_q - r_p;
    assign trial    = {r_rem[RW-2:0], r_dlo[CB-1]};
    assign trial_ge = trial >= RW'(r_den);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (o_m_tvalid && i_m_tready && r_state != ST_DONE) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (s_acc && s_mode == MODE_QUERY) begin
                        r_base <= AW'(32'(s_ch) * BINS);
                        r_cp1  <= (IDX_W + 1)'(s_idx) + 1'b1;
                        if (ch_ok) begin
                            r_state <= ST_RDT;
                        end else begin
                            r_res   <= '0;
                            r_state <= ST_DONE;
                        end
                    end
                end
                ST_RDT: r_state <= ST_T;
                ST_T: begin
                    r_total <= ram_rdata;
                    r_tgt   <= TW'(r_cp1) * TW'(ram_rdata);
                    r_ra    <= IX'(1);
                    r_ci    <= '0;
                    r_prev  <= '0;
                    if (ram_rdata == '0) begin
                        r_res   <= '0;
                        r_state <= ST_DONE;
                    end else begin
                        r_state <= ST_SCAN;
                    end
                end
                ST_SCAN: begin
                    // ram_rdata holds bin r_ci; first qualifying bin wins
                    r_ra <= r_ra + 1'b1;
                    if (hit) begin
                        r_q     <= ram_rdata;
                        r_p     <= r_prev;
                        r_state <= ST_PQ;
                    end else if (r_ci == IX'(BINS - 1)) begin
                        r_res   <= QW'(r_total);   // no bin qualifies
                        r_state <= ST_DONE;
                    end else begin
                        r_prev <= ram_rdata;
                        r_ci   <= r_ci + 1'b1;
                    end
                end
                ST_PQ: begin
                    r_prod  <= (IX + CB)'(r_ci) * (IX + CB)'(span);
                    r_den   <= DEN_W'(span) * DEN_W'(KD);
                    r_state <= ST_NUM;
                end
                ST_NUM: begin
                    // 255*i*span + target - 255*p, never negative
                    r_num   <= (NUM_W'(r_prod) << 8) - NUM_W'(r_prod) + NUM_W'(r_tgt)
                               - ((NUM_W'(r_p) << 8) - NUM_W'(r_p));
                    r_acc   <= '0;
                    r_mulb  <= r_total;
                    r_cnt   <= CNT_W'(CB);
                    r_state <= ST_MUL;
                end
                ST_MUL: begin
                    // MSB-first shift-add of num * T
                    r_acc  <= (r_acc << 1) + (r_mulb[CB-1] ? PW'(r_num) : '0);
                    r_mulb <= r_mulb << 1;
                    r_cnt  <= r_cnt - 1'b1;
                    if (r_cnt == CNT_W'(1)) begin
                        r_state <= ST_DIVI;
                    end
                end
                ST_DIVI: begin
                    // quotient fits CB bits, so the upper part is already below den
                    r_rem   <= RW'(r_acc[PW-1:CB]);
                    r_dlo   <= r_acc[CB-1:0];
                    r_quo   <= '0;
                    r_cnt   <= CNT_W'(CB);
                    r_state <= ST_DIV;
                end
                ST_DIV: begin
                    r_rem  <= trial_ge ? trial - RW'(r_den) : trial;
                    r_quo  <= {r_quo[CB-2:0], trial_ge};
                    r_dlo  <= r_dlo << 1;
                    r_cnt  <= r_cnt - 1'b1;
                    if (r_cnt == CNT_W'(1)) begin
                        r_state <= ST_FIN;
                    end
                end
                ST_FIN: begin
                    r_res   <= QW'(r_quo) + QW'(r_rem != '0);   // ceiling
                    r_state <= ST_DONE;
                end
                ST_DONE: begin
                    if (!r_out_valid || i_m_tready) begin
                        r_out_valid <= 1'b1;
                        r_out_data  <= OUT_W'(r_res);
                        r_state     <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

endmodule

### tb/tb.sv
// Testbench for histogram_inverse_cdf_table: loads cdf tables, queries inverse entries.
// Depends on hict_pkg and the block's RTL; checks each result against its own predictor.
`timescale 1ns / 1ps

module tb;
    import hict_pkg::*;

    localparam int NCH        = DEF_CHANNELS;
    localparam int NLOAD      = 3;       // channels loaded and queried
    localparam int NBINS      = DEF_BINS;
    localparam int LIMIT_CYC  = 1000000;
    localparam int TAIL_CYC   = 200;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_s_tvalid;
    logic                o_s_tready;
    logic [S_DATA_W-1:0] i_s_tdata;   // index[7:0], cdf_value[31:8]
    logic [S_USER_W-1:0] i_s_tuser;   // mode[0], channel[2:1]
    logic                o_m_tvalid;
    logic                i_m_tready;
    logic [M_DATA_W-1:0] o_m_tdata;   // inverse_value[23:0]

    // Predictor copy of the cdf store
    logic [VAL_W-1:0] cdf_copy [NCH][NBINS];
    logic [OUT_W-1:0] inv_expected [$];

    int  n_errors;
    int  cyc;
    bit  calm;          // no idling on either side
    int  hold_req;      // receiver hold-off, in cycles

    histogram_inverse_cdf_table dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Inverse cdf entry c of channel ch, exact rational arithmetic
    function automatic logic [OUT_W-1:0] inv_entry(int ch, int c);
        logic [63:0]  tot, tgt, prv, q, span, num;
        logic [127:0] wide, den;
        tot = cdf_copy[ch][NBINS-1];
        tgt = (c + 1) * tot;
        prv = 0;
        if (tot == 0) return '0;
        for (int i = 0; i < NBINS; i++) begin
            q = cdf_copy[ch][i];
            if (q * OUT_SCALE >= tgt) begin
                span = q - prv;
                num  = OUT_SCALE * i * span + tgt - OUT_SCALE * prv;
                wide = 128'(num) * 128'(tot);
                den  = 128'(NBINS) * OUT_SCALE * span;
                wide = (wide + den - 1) / den;
                return wide[OUT_W-1:0];
            end
            prv = q;
        end
        return tot[OUT_W-1:0];
    endfunction

    // Sends one item, waits for acceptance, updates the predictor
    task automatic send_item(logic mode, int ch, int idx, logic [VAL_W-1:0] val);
        int gap;
        gap = (!calm && $urandom_range(0, 3) == 0) ? $urandom_range(1, 13) : 0;
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {val, idx[IDX_W-1:0]};
        i_s_tuser  <= {ch[CH_W-1:0], mode};
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        if (mode == MODE_LOAD) cdf_copy[ch][idx] = val;
        else inv_expected.push_back(inv_entry(ch, idx));
    endtask

    task automatic wait_drained();
        i_s_tvalid <= 1'b0;
        while (inv_expected.size() != 0) @(posedge i_clk);
        // a trailing load may still be in flight
        repeat (100) @(posedge i_clk);
    endtask

    // Whole channel with one of several shapes
    task automatic load_channel(int ch, int shape);
        logic [VAL_W-1:0] acc, v;
        int step_bin;
        acc = 0;
        step_bin = $urandom_range(0, NBINS - 1);
        for (int b = 0; b < NBINS; b++) begin
            case (shape)
                0: begin                       // nondecreasing, random steps
                    acc = acc + 24'($urandom_range(0, 60000));
                    v = acc;
                end
                1: v = '0;                     // zero total
                2: v = (b == NBINS - 1) ? 24'hFFFFFF : 24'(b * 65793);  // full-scale ramp
                3: v = (b >= step_bin) ? 24'($urandom_range(1, 24'hFFFFFF)) & 24'hFFFFFF
                                       : 24'h0;  // single jump, rest flat
                4: v = 24'($urandom());        // not nondecreasing
                default: begin                 // small counts, sparse
                    if ($urandom_range(0, 7) == 0) acc = acc + 24'($urandom_range(1, 3));
                    v = acc;
                end
            endcase
            if (shape == 3 && b > step_bin) v = cdf_copy[ch][step_bin];
            send_item(MODE_LOAD, ch, b, v);
        end
    endtask

    task automatic test_table_setup();
        load_channel(0, 0);
        load_channel(1, 4);
        load_channel(2, 2);
    endtask

    // Extreme and middle entries on every loaded channel: first, last (no bin found when monotone)
    task automatic test_entry_extremes();
        int cs [5] = '{0, 1, 127, 254, 255};
        for (int ch = 0; ch < NLOAD; ch++)
            foreach (cs[k]) send_item(MODE_QUERY, ch, cs[k], 24'($urandom()));
        wait_drained();
    endtask

    // Last bin cleared: zero total, then rewritten with a random value
    task automatic test_zero_total();
        int cs [3] = '{0, 128, 255};
        send_item(MODE_LOAD, 1, NBINS - 1, '0);
        foreach (cs[k]) send_item(MODE_QUERY, 1, cs[k], 24'($urandom()));
        send_item(MODE_LOAD, 1, NBINS - 1, 24'($urandom()));
        wait_drained();
    endtask

    task automatic test_backpressure();
        hold_req = 600;
        for (int k = 0; k < 20; k++)
            send_item(MODE_QUERY, $urandom_range(0, NLOAD - 1), $urandom_range(0, 255),
                      24'($urandom()));
        wait_drained();
    endtask

    task automatic test_random_traffic(int n);
        for (int k = 0; k < n; k++) begin
            if (k == n - n / 4) calm = 1'b1;
            if ($urandom_range(0, 9) < 7) begin
                send_item(MODE_QUERY, $urandom_range(0, NLOAD - 1), $urandom_range(0, 255),
                          24'($urandom()));
            end else begin
                // single rewrite: may break monotonicity
                send_item(MODE_LOAD, $urandom_range(0, NLOAD - 1), $urandom_range(0, 255),
                          24'($urandom()));
            end
        end
    endtask

    // Receiver: random stalls, plus the long hold-off on request
    initial begin
        int burst;
        i_m_tready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req > 0) begin
                i_m_tready <= 1'b0;
                repeat (hold_req) @(posedge i_clk);
                hold_req = 0;
            end else if (!calm && $urandom_range(0, 5) == 0) begin
                burst = $urandom_range(1, 13);
                i_m_tready <= 1'b0;
                repeat (burst - 1) @(posedge i_clk);
            end else begin
                i_m_tready <= 1'b1;
            end
        end
    end

    // Result check against the oldest expectation
    always @(posedge i_clk) begin
        logic [OUT_W-1:0] want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (inv_expected.size() == 0) begin
                $error("unexpected result: inverse_value actual %0d", o_m_tdata);
                n_errors++;
            end else begin
                want = inv_expected.pop_front();
                if (o_m_tdata !== want) begin
                    $error("inverse_value: expected %0d, actual %0d", want, o_m_tdata);
                    n_errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cyc++;
        if (cyc > LIMIT_CYC) begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial begin
        n_errors   = 0;
        cyc        = 0;
        calm       = 1'b0;
        hold_req   = 0;
        i_rst_n    = 1'b0;
        i_s_tvalid = 1'b0;
        i_s_tdata  = '0;
        i_s_tuser  = '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_table_setup();
        test_entry_extremes();
        test_zero_total();
        test_backpressure();
        test_random_traffic(100);

        wait_drained();
        repeat (TAIL_CYC) @(posedge i_clk);
        if (n_errors == 0 && inv_expected.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

### histogram_inverse_cdf_table.f
src/hict_pkg.sv
src/hict_ram.sv
src/histogram_inverse_cdf_table.sv
tb/tb.sv
